### sv/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg
// Shared types and constants for the numeric literal scanner.
// ----------------------------------------------------------------------------
package nls_pkg;

  localparam int unsigned MAX_LEN_DEF = 255;
  localparam int unsigned CNT_W       = 8;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd1,
    PH_SIGNED  = 3'd2,
    PH_ZERO    = 3'd3,
    PH_BODY    = 3'd4,
    PH_EXPSIGN = 3'd5,
    PH_EXPDIG  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  typedef struct packed {
    phase_t           phase;
    base_t            base_sel;
    logic             dot_seen;
    logic             exp_seen;
    logic             minus_seen;
    logic             text_empty;
    logic [CNT_W-1:0] count;
  } scan_st_t;

  typedef struct packed {
    logic kept;
    logic zero_inserted;
    logic finished;
  } scan_flags_t;

  localparam scan_st_t SCAN_RST = '{
    phase:      PH_IDLE,
    base_sel:   BASE_DEC,
    dot_seen:   1'b0,
    exp_seen:   1'b0,
    minus_seen: 1'b0,
    text_empty: 1'b1,
    count:      '0
  };

endpackage

### sv/numeric_literal_scanner.sv
// ----------------------------------------------------------------------------
// numeric_literal_scanner
// Character-serial lexer for signed binary, octal, decimal and hex literals.
// ----------------------------------------------------------------------------
// One character word is taken per cycle with no bubbles while the result side
// does not stall; an accepted character is held in the input register, and its
// result word is loaded from there into the result register, which drives
// out_valid. Throughput is set by the scan state update, which is a loop from
// the state register through the step logic and back. Stalls on the result side
// hold the input register and then drop in_ready.
module numeric_literal_scanner #(
  parameter int unsigned MAX_LEN = nls_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_first,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kept,
  output logic       out_zero_inserted,
  output logic       out_finished,
  output logic [7:0] out_length,
  output logic [1:0] out_base_code,
  output logic       out_is_float,
  output logic       out_has_exponent,
  output logic       out_negative
);

  logic       stg_valid_r;
  logic [7:0] stg_ch_r;
  logic       stg_first_r;
  logic       stg_last_r;

  nls_pkg::scan_st_t    st_r, st_nxt;
  nls_pkg::scan_flags_t flags;
  nls_pkg::scan_flags_t out_flags_r;
  nls_pkg::scan_st_t    out_st_r;
  logic                 out_valid_r;
  logic                 advance;

  assign advance  = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_ch_r    <= in_ch;
      stg_first_r <= in_first;
      stg_last_r  <= in_last;
    end
  end

  nls_step #(
    .MAX_LEN(MAX_LEN)
  ) u_step (
    .st     (st_r),
    .ch     (stg_ch_r),
    .first  (stg_first_r),
    .last   (stg_last_r),
    .st_nxt (st_nxt),
    .flags  (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= nls_pkg::SCAN_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flags_r <= flags;
      out_st_r    <= st_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kept          = out_flags_r.kept;
  assign out_zero_inserted = out_flags_r.zero_inserted;
  assign out_finished      = out_flags_r.finished;
  assign out_length        = out_st_r.count;
  assign out_base_code     = out_st_r.base_sel;
  assign out_is_float      = out_st_r.dot_seen;
  assign out_has_exponent  = out_st_r.exp_seen;
  assign out_negative      = out_st_r.minus_seen;

  // a finished word always leaves the scanner idle
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && flags.finished |=> st_r.phase == nls_pkg::PH_IDLE)
    else $error("scanner not idle after finished word");

  // inserted zero only ever comes with a kept dot
  a_zins_dot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_inserted |-> out_kept && out_is_float)
    else $error("zero inserted without a kept dot");

  // exponent only exists in decimal literals
  a_exp_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_exponent |-> out_base_code == nls_pkg::BASE_DEC)
    else $error("exponent outside decimal base");

  // a stalled result keeps the staged word and the scan state in place
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid_r && out_valid_r && !out_ready |=> stg_valid_r && $stable(st_r))
    else $error("scan state moved during result stall");

endmodule

### sv/nls_step.sv
// ----------------------------------------------------------------------------
// nls_step
// Single-character scan step: next scan state and per-character flags.
// ----------------------------------------------------------------------------
module nls_step #(
  parameter int unsigned MAX_LEN = nls_pkg::MAX_LEN_DEF
) (
  input  nls_pkg::scan_st_t    st,
  input  logic [7:0]           ch,
  input  logic                 first,
  input  logic                 last,
  output nls_pkg::scan_st_t    st_nxt,
  output nls_pkg::scan_flags_t flags
);

  localparam int unsigned LenCapInt = (MAX_LEN > 255) ? 255 : MAX_LEN;
  localparam logic [nls_pkg::CNT_W-1:0] LenCap = nls_pkg::CNT_W'(LenCapInt);

  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChLoE   = 8'h65;
  localparam logic [7:0] ChUpE   = 8'h45;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChZero  = 8'h30;

  nls_pkg::scan_st_t s0;
  nls_pkg::base_t    base_eff;
  logic is_sign, is_dec, is_01, is_27, is_89, is_hexl, is_e;
  logic go_signed, zero_other, go_body, go_expdig;
  logic kept, consumed, reject, zins;

  always_comb begin
    s0 = first ? nls_pkg::SCAN_RST : st;
    if (first) begin
      s0.phase = nls_pkg::PH_START;
    end

    is_sign = (ch == ChMinus) || (ch == ChPlus);
    is_dec  = (ch >= 8'h30) && (ch <= 8'h39);
    is_01   = (ch == 8'h30) || (ch == 8'h31);
    is_27   = (ch >= 8'h32) && (ch <= 8'h37);
    is_89   = (ch == 8'h38) || (ch == 8'h39);
    is_hexl = ((ch >= 8'h61) && (ch <= 8'h64)) || (ch == 8'h66) ||
              ((ch >= 8'h41) && (ch <= 8'h44)) || (ch == 8'h46);
    is_e    = (ch == ChLoE) || (ch == ChUpE);

    // fall-through chains: start -> signed -> body, zero -> body, exp sign -> exp digits
    go_signed  = (s0.phase == nls_pkg::PH_SIGNED) ||
                 ((s0.phase == nls_pkg::PH_START) && !is_sign);
    zero_other = (s0.phase == nls_pkg::PH_ZERO) &&
                 !((ch == ChX) || (ch == ChB) || (ch == ChDot));
    go_body    = (s0.phase == nls_pkg::PH_BODY) || (go_signed && (ch != ChZero)) ||
                 zero_other;
    go_expdig  = (s0.phase == nls_pkg::PH_EXPDIG) ||
                 ((s0.phase == nls_pkg::PH_EXPSIGN) && !is_sign);
    base_eff   = zero_other ? nls_pkg::BASE_OCT : s0.base_sel;

    st_nxt   = s0;
    kept     = 1'b0;
    consumed = 1'b0;
    reject   = 1'b0;
    zins     = 1'b0;

    if (s0.phase != nls_pkg::PH_IDLE) begin
      if ((s0.phase == nls_pkg::PH_START) && is_sign) begin
        consumed          = 1'b1;
        st_nxt.minus_seen = (ch == ChMinus);
        st_nxt.phase      = nls_pkg::PH_SIGNED;
      end else if (go_signed && (ch == ChZero)) begin
        kept         = 1'b1;
        st_nxt.phase = nls_pkg::PH_ZERO;
      end else if ((s0.phase == nls_pkg::PH_ZERO) && !zero_other) begin
        kept         = 1'b1;
        st_nxt.phase = nls_pkg::PH_BODY;
        priority if (ch == ChX) begin
          st_nxt.base_sel = nls_pkg::BASE_HEX;
        end else if (ch == ChB) begin
          st_nxt.base_sel = nls_pkg::BASE_BIN;
        end else begin
          st_nxt.base_sel = nls_pkg::BASE_DEC;
          st_nxt.dot_seen = 1'b1;
        end
      end else if (go_body) begin
        st_nxt.phase    = nls_pkg::PH_BODY;
        st_nxt.base_sel = base_eff;
        priority if (is_01) begin
          kept = 1'b1;
        end else if (is_27) begin
          kept = (base_eff != nls_pkg::BASE_BIN);
        end else if (is_89) begin
          kept = (base_eff == nls_pkg::BASE_DEC) || (base_eff == nls_pkg::BASE_HEX);
        end else if (is_hexl) begin
          kept = (base_eff == nls_pkg::BASE_HEX);
        end else if (ch == ChDot) begin
          if (!s0.dot_seen) begin
            kept            = 1'b1;
            zins            = s0.text_empty;
            st_nxt.dot_seen = 1'b1;
          end
        end else if (is_e) begin
          if (base_eff == nls_pkg::BASE_HEX) begin
            kept = 1'b1;
          end else if (base_eff == nls_pkg::BASE_DEC) begin
            kept            = 1'b1;
            st_nxt.exp_seen = 1'b1;
            st_nxt.phase    = nls_pkg::PH_EXPSIGN;
          end
        end else begin
          kept = 1'b0;
        end
        reject = !kept;
      end else if ((s0.phase == nls_pkg::PH_EXPSIGN) && is_sign) begin
        kept         = 1'b1;
        st_nxt.phase = nls_pkg::PH_EXPDIG;
      end else if (go_expdig) begin
        st_nxt.phase = nls_pkg::PH_EXPDIG;
        kept         = is_dec;
        reject       = !is_dec;
      end

      if (kept) begin
        consumed          = 1'b1;
        st_nxt.text_empty = 1'b0;
      end
      if (consumed && (s0.count < LenCap)) begin
        st_nxt.count = s0.count + 1'b1;
      end
      if (reject || last) begin
        st_nxt.phase = nls_pkg::PH_IDLE;
      end
    end

    flags.kept          = kept;
    flags.zero_inserted = zins;
    flags.finished      = (s0.phase != nls_pkg::PH_IDLE) && (reject || last);
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the numeric literal scanner. A queue of character
// words (directed literals, then random literals and noise) feeds a clocked
// driver; a clocked monitor predicts each result word from the scan rules
// and compares it with what the block returns, under several idle patterns
// and one long result-side stall.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int HOLD_CYCLES = 150;
  localparam int WDOG_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 16;
  localparam int LEN_CAP     = (nls_pkg::MAX_LEN_DEF > 255) ? 255 : nls_pkg::MAX_LEN_DEF;

  localparam logic [7:0] CH_D0    = "0";
  localparam logic [7:0] CH_D1    = "1";
  localparam logic [7:0] CH_D2    = "2";
  localparam logic [7:0] CH_D7    = "7";
  localparam logic [7:0] CH_D8    = "8";
  localparam logic [7:0] CH_D9    = "9";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LD    = "d";
  localparam logic [7:0] CH_LF    = "f";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UD    = "D";
  localparam logic [7:0] CH_UF    = "F";
  localparam logic [7:0] CH_LE    = "e";
  localparam logic [7:0] CH_UE    = "E";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_LB    = "b";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
  } char_word_t;

  typedef struct packed {
    logic           kept;
    logic           zero_inserted;
    logic           finished;
    logic [7:0]     length;
    nls_pkg::base_t base_code;
    logic           is_float;
    logic           has_exponent;
    logic           negative;
  } scan_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_ch = 8'h00;
  logic       in_first = 1'b0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_kept;
  logic       out_zero_inserted;
  logic       out_finished;
  logic [7:0] out_length;
  logic [1:0] out_base_code;
  logic       out_is_float;
  logic       out_has_exponent;
  logic       out_negative;

  numeric_literal_scanner dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_ch             (in_ch),
    .in_first          (in_first),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kept          (out_kept),
    .out_zero_inserted (out_zero_inserted),
    .out_finished      (out_finished),
    .out_length        (out_length),
    .out_base_code     (out_base_code),
    .out_is_float      (out_is_float),
    .out_has_exponent  (out_has_exponent),
    .out_negative      (out_negative)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  char_word_t char_q[$];
  scan_word_t scan_expect_q[$];

  bit tb_go = 1'b0;
  bit in_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int queued_total = 0;
  int mism_cnt = 0;
  int result_idx = 0;
  int quiet_cycles = 0;

  // scanner state as the bench tracks it
  nls_pkg::phase_t sc_phase = nls_pkg::PH_IDLE;
  nls_pkg::base_t  sc_base = nls_pkg::BASE_DEC;
  logic            sc_dot = 1'b0;
  logic            sc_exp = 1'b0;
  logic            sc_minus = 1'b0;
  logic            sc_empty = 1'b1;
  logic [7:0]      sc_count = 8'd0;

  function automatic scan_word_t scan_char(input logic [7:0] c, input logic fst,
                                           input logic lst);
    scan_word_t r;
    logic consumed, keep, zins, rej, redo, fin;
    consumed = 1'b0;
    keep = 1'b0;
    zins = 1'b0;
    rej = 1'b0;
    fin = 1'b0;
    if (fst) begin
      sc_base = nls_pkg::BASE_DEC;
      sc_dot = 1'b0;
      sc_exp = 1'b0;
      sc_minus = 1'b0;
      sc_empty = 1'b1;
      sc_count = 8'd0;
      sc_phase = nls_pkg::PH_START;
    end
    if (sc_phase != nls_pkg::PH_IDLE) begin
      redo = 1'b1;
      // a character can fall through several phases before it is judged
      while (redo) begin
        redo = 1'b0;
        case (sc_phase)
          nls_pkg::PH_START: begin
            sc_phase = nls_pkg::PH_SIGNED;
            if (c == CH_MINUS || c == CH_PLUS) begin
              if (c == CH_MINUS) sc_minus = 1'b1;
              consumed = 1'b1;
            end else begin
              redo = 1'b1;
            end
          end
          nls_pkg::PH_SIGNED: begin
            if (c == CH_D0) begin
              keep = 1'b1;
              sc_phase = nls_pkg::PH_ZERO;
            end else begin
              sc_phase = nls_pkg::PH_BODY;
              redo = 1'b1;
            end
          end
          nls_pkg::PH_ZERO: begin
            sc_phase = nls_pkg::PH_BODY;
            if (c == CH_LX) begin
              sc_base = nls_pkg::BASE_HEX;
              keep = 1'b1;
            end else if (c == CH_LB) begin
              sc_base = nls_pkg::BASE_BIN;
              keep = 1'b1;
            end else if (c == CH_DOT) begin
              sc_base = nls_pkg::BASE_DEC;
              sc_dot = 1'b1;
              keep = 1'b1;
            end else begin
              sc_base = nls_pkg::BASE_OCT;
              redo = 1'b1;
            end
          end
          nls_pkg::PH_BODY: begin
            if (c == CH_D0 || c == CH_D1) begin
              keep = 1'b1;
            end else if (c >= CH_D2 && c <= CH_D7) begin
              keep = (sc_base != nls_pkg::BASE_BIN);
            end else if (c == CH_D8 || c == CH_D9) begin
              keep = (sc_base == nls_pkg::BASE_DEC || sc_base == nls_pkg::BASE_HEX);
            end else if ((c >= CH_LA && c <= CH_LD) || c == CH_LF ||
                         (c >= CH_UA && c <= CH_UD) || c == CH_UF) begin
              keep = (sc_base == nls_pkg::BASE_HEX);
            end else if (c == CH_DOT) begin
              if (!sc_dot) begin
                if (sc_empty) zins = 1'b1;
                sc_dot = 1'b1;
                keep = 1'b1;
              end
            end else if (c == CH_LE || c == CH_UE) begin
              if (sc_base == nls_pkg::BASE_HEX) begin
                keep = 1'b1;
              end else if (sc_base == nls_pkg::BASE_DEC) begin
                sc_exp = 1'b1;
                sc_phase = nls_pkg::PH_EXPSIGN;
                keep = 1'b1;
              end
            end
            if (!keep) rej = 1'b1;
          end
          nls_pkg::PH_EXPSIGN: begin
            sc_phase = nls_pkg::PH_EXPDIG;
            if (c == CH_PLUS || c == CH_MINUS) keep = 1'b1;
            else redo = 1'b1;
          end
          default: begin
            if (c >= CH_D0 && c <= CH_D9) keep = 1'b1;
            else rej = 1'b1;
          end
        endcase
      end
      if (keep) begin
        consumed = 1'b1;
        sc_empty = 1'b0;
      end
      if (consumed && sc_count < LEN_CAP) sc_count = sc_count + 8'd1;
      if (rej || lst) begin
        fin = 1'b1;
        sc_phase = nls_pkg::PH_IDLE;
      end
    end
    r.kept = keep;
    r.zero_inserted = zins;
    r.finished = fin;
    r.length = sc_count;
    r.base_code = sc_base;
    r.is_float = sc_dot;
    r.has_exponent = sc_exp;
    r.negative = sc_minus;
    return r;
  endfunction

  function automatic logic [7:0] rand_digit(input nls_pkg::base_t b);
    int k;
    k = $urandom_range(21);
    case (b)
      nls_pkg::BASE_BIN: return 8'(CH_D0 + $urandom_range(1));
      nls_pkg::BASE_OCT: return 8'(CH_D0 + $urandom_range(7));
      nls_pkg::BASE_DEC: return 8'(CH_D0 + $urandom_range(9));
      default: begin
        if (k < 10) return 8'(CH_D0 + k);
        else if (k < 16) return 8'(CH_LA + (k - 10));
        else return 8'(CH_UA + (k - 16));
      end
    endcase
  endfunction

  task automatic push_char(input logic [7:0] c, input logic f, input logic l);
    char_word_t w;
    w.ch = c;
    w.first = f;
    w.last = l;
    char_q = {char_q, w};
    queued_total++;
  endtask

  task automatic push_text(input string s, input logic last_on_end);
    int i;
    for (i = 0; i < s.len(); i++)
      push_char(s[i], i == 0, last_on_end && (i == s.len() - 1));
  endtask

  // one literal: optional sign, prefix, body, exponent, then how it ends
  task automatic add_literal(input int ndig);
    logic [7:0] txt[$];
    nls_pkg::base_t b;
    logic dotted, end_last;
    int i, ntail;
    txt = {};
    b = nls_pkg::BASE_DEC;
    dotted = 1'b0;
    end_last = 1'b0;
    case ($urandom_range(3))
      0: txt = {txt, CH_PLUS};
      1: txt = {txt, CH_MINUS};
      default: ;
    endcase
    case ($urandom_range(7))
      0: begin
        txt = {txt, CH_D0, CH_LX};
        b = nls_pkg::BASE_HEX;
      end
      1: begin
        txt = {txt, CH_D0, CH_LB};
        b = nls_pkg::BASE_BIN;
      end
      2: begin
        txt = {txt, CH_D0};
        b = nls_pkg::BASE_OCT;
      end
      3: begin
        txt = {txt, CH_D0, CH_DOT};
        dotted = 1'b1;
      end
      4: begin
        txt = {txt, CH_DOT};
        dotted = 1'b1;
      end
      5: ; // body starts right away, may open with e
      default: txt = {txt, 8'(CH_D1 + $urandom_range(8))};
    endcase
    for (i = 0; i < ndig; i++) begin
      if (!dotted && $urandom_range(7) == 0) begin
        txt = {txt, CH_DOT};
        dotted = 1'b1;
      end else begin
        txt = {txt, rand_digit(b)};
      end
    end
    if (b == nls_pkg::BASE_DEC && $urandom_range(2) == 0) begin
      txt = {txt, ($urandom_range(1) != 0) ? CH_UE : CH_LE};
      case ($urandom_range(2))
        0: txt = {txt, CH_PLUS};
        1: txt = {txt, CH_MINUS};
        default: ;
      endcase
      for (i = $urandom_range(3); i > 0; i--) txt = {txt, rand_digit(nls_pkg::BASE_DEC)};
    end
    if (txt.size() == 0) txt = {txt, rand_digit(nls_pkg::BASE_DEC)};
    case ($urandom_range(3))
      0: end_last = 1'b1;
      1, 2: txt = {txt, 8'($urandom_range(255))};
      default: ; // cut off by the next first
    endcase
    for (i = 0; i < txt.size(); i++)
      push_char(txt[i], i == 0, end_last && (i == txt.size() - 1));
    // stray words after the end
    ntail = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
    for (i = 0; i < ntail; i++)
      push_char(8'($urandom_range(255)), 1'b0, $urandom_range(3) == 0);
  endtask

  task automatic add_random(input int n);
    int start, k;
    start = queued_total;
    while (queued_total - start < n) begin
      if ($urandom_range(9) < 8) begin
        add_literal(($urandom_range(19) == 0) ? 12 : $urandom_range(6));
      end else begin
        for (k = $urandom_range(1, 4); k > 0; k--)
          push_char(8'($urandom_range(255)), $urandom_range(3) == 0, $urandom_range(3) == 0);
      end
    end
  endtask

  task automatic wait_drained();
    while (char_q.size() != 0 || in_valid || scan_expect_q.size() != 0) @(posedge clk);
  endtask

  // driver: new word at the falling edge once the last one was taken
  always @(negedge clk) begin
    char_word_t w;
    if (tb_go) begin
      if (!in_valid || in_taken) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = char_q.pop_front();
          in_valid <= 1'b1;
          in_ch <= w.ch;
          in_first <= w.first;
          in_last <= w.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus a long hold on request
  always @(negedge clk) begin
    if (tb_go) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // monitor: predict on input words, check on result words
  always @(posedge clk) begin
    scan_word_t got, want;
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) scan_expect_q = {scan_expect_q, scan_char(in_ch, in_first, in_last)};
    if (rst_n && out_valid && out_ready) begin
      got.kept = out_kept;
      got.zero_inserted = out_zero_inserted;
      got.finished = out_finished;
      got.length = out_length;
      got.base_code = nls_pkg::base_t'(out_base_code);
      got.is_float = out_is_float;
      got.has_exponent = out_has_exponent;
      got.negative = out_negative;
      if (scan_expect_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10) $display("result word %0d arrived with nothing expected", result_idx);
      end else begin
        want = scan_expect_q.pop_front();
        if (got.kept !== want.kept || got.zero_inserted !== want.zero_inserted ||
            got.finished !== want.finished || got.length !== want.length ||
            got.base_code !== want.base_code || got.is_float !== want.is_float ||
            got.has_exponent !== want.has_exponent || got.negative !== want.negative) begin
          mism_cnt++;
          if (mism_cnt <= 10) begin
            $display("word %0d exp: kept=%b zi=%b fin=%b len=%0d base=%0d flt=%b exp=%b neg=%b",
                     result_idx, want.kept, want.zero_inserted, want.finished, want.length,
                     want.base_code, want.is_float, want.has_exponent, want.negative);
            $display("word %0d got: kept=%b zi=%b fin=%b len=%0d base=%0d flt=%b exp=%b neg=%b",
                     result_idx, got.kept, got.zero_inserted, got.finished, got.length,
                     got.base_code, got.is_float, got.has_exponent, got.negative);
          end
        end
      end
      result_idx++;
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (tb_go && !(in_valid && in_ready) && !(out_valid && out_ready)) quiet_cycles++;
    else quiet_cycles = 0;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int ph, i;
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 58, 0, 11};
    recv_pct = '{0, 0, 58, 11};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tb_go = 1'b1;

    // directed: prefixes, bad digits, leading dot and e, sign alone, byte extremes
    push_text("-0xEg", 1'b0);
    push_text("+0b12", 1'b0);
    push_text("08", 1'b0);
    push_text(".5e-3", 1'b1);
    push_text("e9", 1'b1);
    push_text("0..", 1'b0);
    push_text("-", 1'b1);
    push_char(8'hFF, 1'b1, 1'b0);
    push_char(8'h00, 1'b0, 1'b0);
    push_char(CH_D7, 1'b1, 1'b1);
    wait_drained();

    // result side holds off while words keep coming
    hold_req++;
    add_random(40);
    wait_drained();

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      add_random(70);
      if (ph == 0) begin
        // runs past the length limit
        push_char(CH_D1, 1'b1, 1'b0);
        for (i = 0; i < 268; i++) push_char(rand_digit(nls_pkg::BASE_DEC), 1'b0, 1'b0);
        push_char(CH_D9, 1'b0, 1'b1);
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk);
    mism_cnt += scan_expect_q.size();
    if (mism_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
